// File: rtl/ppp_pkg.sv
package ppp_pkg;

  localparam int COORD_BITS    = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int LEN_FRAC_BITS = 8;

  // Rotation datapath: 64-bit signed x and y, 32-bit angle accumulator.
  localparam int CORDIC_W      = 64;
  localparam int Z_W           = 32;
  localparam int CORDIC_STEPS  = 32;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int HEADROOM      = 60 - COORD_BITS;

  // Squared length, scaled for the fraction bits, and the digit-by-digit root.
  localparam int SQR_W         = 2 * COORD_BITS;
  localparam int SUM_W         = 2 * COORD_BITS + 1 + 2 * LEN_FRAC_BITS;
  localparam int SQ_W          = SUM_W + 1;
  localparam int SQRT_STEPS    = (SUM_W + 1) / 2;
  localparam int SQRT_TOP      = 2 * (SQRT_STEPS - 1);
  localparam int LENGTH_WIDTH  = SQRT_STEPS;

  // Angle rounding from the accumulator down to the output width.
  localparam int ANGLE_DROP    = Z_W - ANGLE_BITS;
  localparam logic [Z_W-1:0] ANGLE_HALF =
      (ANGLE_DROP == 0) ? '0 : (Z_W'(1) << (ANGLE_DROP - 1));
  localparam logic [Z_W-1:0] Z_HALF_TURN = Z_W'(1) << (Z_W - 1);

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // One word in flight between the rotation/root stages.
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic        [Z_W-1:0]      z;
    logic        [SQ_W-1:0]     r;
    logic        [SQ_W-1:0]     root;
    logic                       deg;
  } step_t;

endpackage

// File: rtl/ppp_front.sv
module ppp_front
  import ppp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  output step_t                        out_word
);

  // Stage 1: differences.
  logic                       v1;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;

  // Stage 2: squares and the rotation start point.
  logic                       v2;
  logic        [SQR_W-1:0]    ax2;
  logic        [SQR_W-1:0]    ay2;
  logic signed [CORDIC_W-1:0] x0;
  logic signed [CORDIC_W-1:0] y0;
  logic        [Z_W-1:0]      z0;
  logic                       deg2;

  logic        [COORD_BITS-1:0] ax;
  logic        [COORD_BITS-1:0] ay;
  logic signed [CORDIC_W-1:0]   vx;
  logic signed [CORDIC_W-1:0]   vy;
  logic signed [CORDIC_W-1:0]   vx_next;
  logic signed [CORDIC_W-1:0]   vy_next;
  logic        [Z_W-1:0]        z_next;
  logic        [SUM_W-1:0]      sum;

  always_comb begin
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    vx = CORDIC_W'(dx);
    vy = -CORDIC_W'(dy);
    // The screen y axis points down, so the rotation works on (dx, -dy).
    if (vx < 0) begin
      vx_next = -vx;
      vy_next = -vy;
      z_next  = Z_HALF_TURN;
    end else begin
      vx_next = vx;
      vy_next = vy;
      z_next  = '0;
    end
    sum = (SUM_W'(ax2) + SUM_W'(ay2)) << (2 * LEN_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
      dy <= {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};

      ax2  <= SQR_W'(ax) * SQR_W'(ax);
      ay2  <= SQR_W'(ay) * SQR_W'(ay);
      x0   <= vx_next <<< HEADROOM;
      y0   <= vy_next <<< HEADROOM;
      z0   <= z_next;
      deg2 <= (dx == '0) && (dy == '0);

      out_word.x    <= x0;
      out_word.y    <= y0;
      out_word.z    <= z0;
      out_word.r    <= SQ_W'(sum);
      out_word.root <= '0;
      out_word.deg  <= deg2;
    end
  end

endmodule

// File: rtl/ppp_step.sv
module ppp_step
  import ppp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [STEP_W-1:0] idx,
  input  logic              in_valid,
  input  step_t             in_word,
  output logic              out_valid,
  output step_t             out_word
);

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic        [SQ_W-1:0]     bitv;
  logic        [SQ_W-1:0]     trial;
  logic        [6:0]          shamt;
  step_t                      word_next;

  always_comb begin
    word_next = in_word;

    // One rotation of the vectoring iteration; the idx shift is fixed per
    // instance, so each stage reduces to two adders and an accumulator add.
    xs = in_word.x >>> idx;
    ys = in_word.y >>> idx;
    if (in_word.y > 0) begin
      word_next.x = in_word.x + ys;
      word_next.y = in_word.y - xs;
      word_next.z = in_word.z + ATAN_TURNS[idx];
    end else begin
      word_next.x = in_word.x - ys;
      word_next.y = in_word.y + xs;
      word_next.z = in_word.z - ATAN_TURNS[idx];
    end

    // One digit of the square root; stages past the last digit pass it on.
    shamt = 7'(SQRT_TOP) - 7'({idx, 1'b0});
    bitv  = SQ_W'(1) << shamt;
    trial = in_word.root + bitv;
    if (32'(idx) < SQRT_STEPS) begin
      if (in_word.r >= trial) begin
        word_next.r    = in_word.r - trial;
        word_next.root = (in_word.root >> 1) + bitv;
      end else begin
        word_next.root = in_word.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// File: rtl/point_pair_to_polar.sv
// Direction and length of the vector from a start point to an end point.
// The angle is the direction of (dx, -dy) with 65536 units per turn, and
// the length has 8 fraction bits, both rounded to nearest; equal points
// give zero for both and raise degenerate. The block is a 36-stage pipeline
// (3 front stages for the differences, squares and rotation setup, 32
// stages that each do one rotation step and one square-root digit, and an
// output register), so a new word can be taken every cycle unless the
// output is stalled. A stall on a valid output word freezes the
// whole pipeline and is passed straight back to in_stall.
module point_pair_to_polar
  import ppp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [ANGLE_BITS-1:0]  angle_turns,
  output logic        [LENGTH_WIDTH-1:0] length_fixed,
  output logic                          degenerate
);

  logic                    en;
  logic [CORDIC_STEPS:0]   vld;
  step_t                   pipe [CORDIC_STEPS+1];
  step_t                   last;
  logic [Z_W-1:0]          z_round;
  logic [SQ_W-1:0]         len;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ppp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (vld[0]),
    .out_word  (pipe[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    ppp_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (STEP_W'(i)),
      .in_valid  (vld[i]),
      .in_word   (pipe[i]),
      .out_valid (vld[i+1]),
      .out_word  (pipe[i+1])
    );
  end

  always_comb begin
    last    = pipe[CORDIC_STEPS];
    z_round = last.z + ANGLE_HALF;
    len     = last.root + SQ_W'(last.r > last.root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= last.deg;
      if (last.deg) begin
        angle_turns  <= '0;
        length_fixed <= '0;
      end else begin
        angle_turns  <= z_round[Z_W-1 -: ANGLE_BITS];
        length_fixed <= len[LENGTH_WIDTH-1:0];
      end
    end
  end

  // A coinciding pair reports nothing but the flag.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (angle_turns == '0 && length_fixed == '0))
    else $error("degenerate word with nonzero angle or length");

  // Any distinct integer points are at least one pixel apart.
  a_len_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !degenerate) |->
      (length_fixed >= LENGTH_WIDTH'(1 << LEN_FRAC_BITS)))
    else $error("length below one pixel for distinct points");

  // While the output is held, no word may move inside the pipeline.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved during output stall");

  // The root stages never leave a remainder above twice the root.
  a_rem: assert property (@(posedge clk) disable iff (rst)
    vld[CORDIC_STEPS] |-> ({1'b0, last.r} <= {last.root, 1'b0}))
    else $error("square root remainder out of range");

endmodule

// File: dv/polar_check.sv
`timescale 1ns / 100ps

module polar_check
  import ppp_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   start_x,
  input  logic signed [COORD_BITS-1:0]   start_y,
  input  logic signed [COORD_BITS-1:0]   end_x,
  input  logic signed [COORD_BITS-1:0]   end_y,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic        [ANGLE_BITS-1:0]   angle_turns,
  input  logic        [LENGTH_WIDTH-1:0] length_fixed,
  input  logic                           degenerate,
  output int                             fail_count,
  output int                             pending,
  output int                             checked_count,
  output int                             degenerate_count
);

  localparam int PRESCALE   = 60 - COORD_BITS;
  localparam int FRAC       = 8;
  localparam int ROT_STEPS  = 32;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h1 << (31 - ANGLE_BITS);

  // atan(2^-i), 2^32 units per turn.
  localparam logic [31:0] ARC_STEP [ROT_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [ANGLE_BITS-1:0]   angle;
    logic [LENGTH_WIDTH-1:0] length;
    logic                    deg;
  } polar_t;

  function automatic polar_t predict_polar(
    input logic signed [COORD_BITS-1:0] sx, sy, ex, ey
  );
    logic signed [63:0] dx, dy, x, y, xs, ys;
    logic [31:0] z, zr;
    logic [63:0] ax, ay, sq, root, rest, probe;
    polar_t p;
    dx = 64'(ex) - 64'(sx);
    dy = 64'(ey) - 64'(sy);
    p = '0;
    if (dx == 0 && dy == 0) begin
      p.deg = 1'b1;
      return p;
    end
    // Vectoring on (dx, -dy): the screen y axis points down.
    x = dx;
    y = -dy;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    x = x <<< PRESCALE;
    y = y <<< PRESCALE;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARC_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARC_STEP[i];
      end
    end
    zr = z + ROUND_HALF;
    p.angle = zr[31 -: ANGLE_BITS];

    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = (ax * ax + ay * ay) << (2 * FRAC);
    root = '0;
    rest = sq;
    probe = 64'h1 << 62;
    while (probe > sq) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // Round to nearest: the remainder exceeds the root past the half point.
    if (rest > root) root = root + 1;
    p.length = root[LENGTH_WIDTH-1:0];
    return p;
  endfunction

  polar_t polar_due [$];
  int n_fail = 0;
  int n_checked = 0;
  int n_degen = 0;

  always @(posedge clk) begin : watch
    polar_t got, want;
    if (rst) begin
      polar_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.angle = angle_turns;
        got.length = length_fixed;
        got.deg = degenerate;
        if (polar_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected word: angle %0d length %0d degenerate %0b",
                     $time, got.angle, got.length, got.deg);
        end else begin
          want = polar_due.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: word %0d mismatch: expected angle %0d length %0d degenerate %0b",
                       $time, n_checked, want.angle, want.length, want.deg);
              $display("  got angle %0d length %0d degenerate %0b",
                       got.angle, got.length, got.deg);
            end
          end
          n_checked++;
          if (want.deg) n_degen++;
        end
      end
      if (in_valid && !in_stall)
        polar_due.insert(polar_due.size(),
                         predict_polar(start_x, start_y, end_x, end_y));
    end
    fail_count <= n_fail;
    pending <= polar_due.size();
    checked_count <= n_checked;
    degenerate_count <= n_degen;
  end

endmodule

// File: dv/tb_point_pair_to_polar.sv
`timescale 1ns / 100ps

module tb_point_pair_to_polar
  import ppp_pkg::*;
();

  localparam int PAIR_COUNT  = 1250;
  localparam int CALM_TAIL   = 150;
  localparam int LATENCY     = 36;
  localparam int LONG_HOLD   = 200;
  localparam int HOLD_AT     = 400;
  localparam int CYCLE_LIMIT = 200000;

  localparam int CMIN = -(1 << (COORD_BITS - 1));
  localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_BITS-1:0] start_x = '0;
  logic signed [COORD_BITS-1:0] start_y = '0;
  logic signed [COORD_BITS-1:0] end_x = '0;
  logic signed [COORD_BITS-1:0] end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ANGLE_BITS-1:0] angle_turns;
  logic [LENGTH_WIDTH-1:0] length_fixed;
  logic degenerate;

  bit tx_gaps = 1'b1;
  bit rx_bursts = 1'b1;
  bit hold_request = 1'b0;
  int pairs_sent = 0;
  int blocked_cycles = 0;
  int cycle_count = 0;
  int fail_count, pending, checked_count, degenerate_count;

  point_pair_to_polar dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_turns(angle_turns), .length_fixed(length_fixed),
    .degenerate(degenerate)
  );

  polar_check check_polar (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_turns(angle_turns), .length_fixed(length_fixed),
    .degenerate(degenerate),
    .fail_count(fail_count), .pending(pending),
    .checked_count(checked_count), .degenerate_count(degenerate_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) blocked_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding.",
               cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_bursts && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Coordinates are carried as int and cut to the port width here.
  task automatic send_pair(input int sx, sy, ex, ey);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= COORD_BITS'(sx);
    start_y <= COORD_BITS'(sy);
    end_x <= COORD_BITS'(ex);
    end_y <= COORD_BITS'(ey);
    do @(posedge clk); while (in_stall);
    pairs_sent++;
  endtask

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return CMIN;
      1: return CMIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return CMAX - 1;
      default: return CMAX;
    endcase
  endfunction

  initial begin
    int sx, sy, ex, ey, tmp;
    int mode, d, directed;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Coinciding points, axes both ways, longest vectors and unit steps.
    send_pair(0, 0, 0, 0);
    send_pair(CMIN, CMIN, CMIN, CMIN);
    send_pair(CMAX, CMAX, CMAX, CMAX);
    send_pair(CMIN, 0, CMAX, 0);
    send_pair(CMAX, 0, CMIN, 0);
    send_pair(0, CMAX, 0, CMIN);
    send_pair(0, CMIN, 0, CMAX);
    send_pair(CMIN, CMIN, CMAX, CMAX);
    send_pair(CMAX, CMAX, CMIN, CMIN);
    send_pair(CMIN, CMAX, CMAX, CMIN);
    send_pair(CMAX, CMIN, CMIN, CMAX);
    send_pair(0, 0, 1, 0);
    send_pair(0, 0, -1, 0);
    send_pair(0, 0, 0, 1);
    send_pair(0, 0, 0, -1);
    send_pair(0, 0, 1, 1);
    send_pair(0, 0, -1, -1);
    send_pair(0, 0, -1, 1);
    send_pair(0, 0, 1, -1);
    send_pair(CMIN, 0, CMAX, 1);
    send_pair(CMIN, 1, CMAX, 0);
    send_pair(100, -200, -300, 400);
    directed = pairs_sent;

    for (int k = 0; k < PAIR_COUNT - directed; k++) begin
      tx_gaps = (k < PAIR_COUNT - directed - CALM_TAIL) && (k % 250 < 200);
      rx_bursts = tx_gaps;
      if (k == HOLD_AT) hold_request = 1'b1;
      mode = $urandom_range(0, 9);
      sx = $urandom;
      sy = $urandom;
      ex = $urandom;
      ey = $urandom;
      case (mode)
        3, 4: begin
          // Short vectors, start kept clear of the coordinate wrap.
          sx = $urandom_range(0, 60000) - 30000;
          sy = $urandom_range(0, 60000) - 30000;
          ex = sx + $urandom_range(0, 16) - 8;
          ey = sy + $urandom_range(0, 16) - 8;
        end
        5: begin
          ex = sx;
          ey = sy;
        end
        6: begin
          if ($urandom_range(0, 1)) ey = sy;
          else ex = sx;
        end
        7: begin
          sx = $urandom_range(0, 4000) - 2000;
          sy = $urandom_range(0, 4000) - 2000;
          d = $urandom_range(1, 30000);
          ex = $urandom_range(0, 1) ? sx + d : sx - d;
          ey = $urandom_range(0, 1) ? sy + d : sy - d;
        end
        8: begin
          sx = extreme_coord();
          sy = extreme_coord();
          ex = extreme_coord();
          ey = extreme_coord();
        end
        9: begin
          sx = CMIN + $urandom_range(0, 15);
          sy = CMIN + $urandom_range(0, 15);
          ex = CMAX - $urandom_range(0, 15);
          ey = CMAX - $urandom_range(0, 15);
          if ($urandom_range(0, 1)) begin
            tmp = sx; sx = ex; ex = tmp;
          end
          if ($urandom_range(0, 1)) begin
            tmp = sy; sy = ey; ey = tmp;
          end
        end
        default: ;
      endcase
      send_pair(sx, sy, ex, ey);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d point pairs (%0d directed); %0d results checked, %0d degenerate.",
             pairs_sent, directed, checked_count, degenerate_count);
    $display("Input held back on %0d cycles, including a %0d-cycle output hold-off.",
             blocked_cycles, LONG_HOLD);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_step.sv
rtl/point_pair_to_polar.sv
dv/polar_check.sv
dv/tb_point_pair_to_polar.sv
